// ----- rtl/skil_pkg.sv -----
package skil_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic               func;
        logic [7:0]         letter_in;
        logic signed [31:0] sort_key;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         letter_out;
        logic signed [31:0] key_out;
        logic               entry_valid;
        logic               last_flag;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         letter;
        logic signed [31:0] key;
    } t_entry;

endpackage

// ----- rtl/skil_obuf.sv -----
module skil_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  skil_pkg::t_out_item  i_item,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_stall,
    output skil_pkg::t_out_item  o_item
);

    logic                r_valid;
    skil_pkg::t_out_item r_item;

    // slot can take a new item when empty or when the held one leaves now
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/sorted_key_insertion_list_unit.sv -----
// Sorted store of (letter, signed key) pairs, up to CAPACITY entries.
// Input channel i_in_valid / o_in_stall carries one item: func selects
// insert or drain. Output channel o_out_valid / i_out_stall carries
// results through a one-item output register.
// Insert: the pair is placed ahead of the first entry whose key is not
// less than its own (newest first among equal keys). One status result,
// last_flag set; status marks a full store, in which case nothing changes.
// The memory's one read port, one write port and one key comparator walk
// the store from the top down; each entry whose key is not less than the
// new one is read in S_IRD and moved up one place in S_ICMP. The pair is
// written where the walk ends, at the bottom or above a smaller key, and
// the next item is taken in the cycle after the result is pushed.
// Drain: every entry leaves in ascending key order, the last one marked,
// each read through the registered port in S_DRD, sent in S_DEMIT; the store is
// then empty. An empty store gives one result with entry_valid low and
// last_flag high. The block works on one item at a time; o_in_stall is high
// while it is busy. A stalled output holds its result and the sequencer
// waits for the slot. Reset empties the store and the output register.
module sorted_key_insertion_list_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  skil_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output skil_pkg::t_out_item  o_out_item
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_IRD   = 3'd1;
    localparam logic [2:0] S_ICMP  = 3'd2;
    localparam logic [2:0] S_DRD   = 3'd3;
    localparam logic [2:0] S_DEMIT = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]                     r_state, n_state;
    logic [skil_pkg::CNT_W-1:0]     r_count, n_count;
    logic [skil_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic signed [31:0]             r_key, n_key;
    logic [7:0]                     r_letter, n_letter;
    logic                           r_full, n_full;

    skil_pkg::t_entry               mem [skil_pkg::CAPACITY];
    skil_pkg::t_entry               r_rd_data;
    logic [skil_pkg::IDX_W-1:0]     rd_addr;
    logic                           wr_en;
    logic [skil_pkg::IDX_W-1:0]     wr_addr;
    skil_pkg::t_entry               wr_data;

    logic                           in_acc;
    logic                           out_free;
    logic                           push;
    skil_pkg::t_out_item            push_item;
    logic                           drain_last;
    logic                           key_lt;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign rd_addr    = (r_state == S_IRD) ? r_idx - skil_pkg::IDX_W'(1) : r_idx;
    assign drain_last = (skil_pkg::CNT_W'(r_idx) + skil_pkg::CNT_W'(1)) == r_count;
    // shared comparator: stored key against the key being inserted
    assign key_lt     = r_rd_data.key < r_key;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_letter  = r_letter;
        n_full    = r_full;
        wr_en     = 1'b0;
        wr_addr   = r_idx;
        wr_data   = '{letter: r_letter, key: r_key};
        push      = 1'b0;
        push_item = '{letter_out: 8'd0, key_out: 32'sd0, entry_valid: 1'b0,
                      last_flag: 1'b1, status: r_full};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key    = i_in_item.sort_key;
                    n_letter = i_in_item.letter_in;
                    n_full   = skil_pkg::STATUS_OK;
                    n_idx    = '0;
                    if (i_in_item.func == skil_pkg::FUNC_DRAIN) begin
                        n_state = (r_count == '0) ? S_RESP : S_DRD;
                    end else if (r_count == skil_pkg::CNT_W'(skil_pkg::CAPACITY)) begin
                        n_full  = skil_pkg::STATUS_FULL;
                        n_state = S_RESP;
                    end else begin
                        n_idx   = r_count[skil_pkg::IDX_W-1:0];
                        n_state = S_IRD;
                    end
                end
            end
            S_IRD: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    n_count = r_count + skil_pkg::CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    n_state = S_ICMP;
                end
            end
            S_ICMP: begin
                wr_en = 1'b1;
                if (key_lt) begin
                    n_count = r_count + skil_pkg::CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    // move the entry below up one place and keep walking
                    wr_data = r_rd_data;
                    n_idx   = r_idx - skil_pkg::IDX_W'(1);
                    n_state = S_IRD;
                end
            end
            S_DRD: begin
                n_state = S_DEMIT;
            end
            S_DEMIT: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_item = '{letter_out: r_rd_data.letter, key_out: r_rd_data.key,
                                  entry_valid: 1'b1, last_flag: drain_last,
                                  status: skil_pkg::STATUS_OK};
                    if (drain_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + skil_pkg::IDX_W'(1);
                        n_state = S_DRD;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_letter <= n_letter;
        r_full   <= n_full;
    end

    skil_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= skil_pkg::CNT_W'(skil_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_entry_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.entry_valid |-> o_out_item.status == skil_pkg::STATUS_OK)
        else $error("drained entry carries a full status");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEMIT) && out_free && drain_last |=> r_count == '0)
        else $error("store not empty after last drained item");

    a_busy_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !out_free || (r_state == S_DEMIT) || (r_state == S_RESP))
        else $error("result pushed outside an output state");

endmodule
